@@ src/bdq_pkg.sv @@
package bdq_pkg;

    // stream payload widths
    localparam int S_TDATA_W = 40;   // item_value, index, zero fill
    localparam int S_TUSER_W = 3;    // req_type
    localparam int M_TDATA_W = 112;  // result fields, zero fill
    localparam int WORD_W    = 32;   // width of value fields on the ports
    localparam int INDEX_W   = 4;
    localparam int COUNT_W   = 5;

    typedef enum logic [2:0] {
        REQ_HEAD_INSERT = 3'd0,
        REQ_TAIL_INSERT = 3'd1,
        REQ_HEAD_REMOVE = 3'd2,
        REQ_TAIL_REMOVE = 3'd3,
        REQ_CONTAINS    = 3'd4,
        REQ_REMOVE_FIRST = 3'd5,
        REQ_READ_INDEX  = 3'd6,
        REQ_CLEAR       = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_SHIFT = 7'b0001000,
        S_RDIDX = 7'b0010000,
        S_FRONT = 7'b0100000,
        S_BACK  = 7'b1000000
    } t_state;

endpackage

@@ src/bounded_deque_with_search_top.sv @@
// channel   dir  tdata (lowest bit up)                                   tuser
// s_axis    in   item_value[31:0], index[35:32], zero fill to 40 bits      req_type[2:0]
// m_axis    out  status[1:0], found[2], read_value[34:3], empty_flag[35],  -
//                entry_count[40:36], front_value[72:41], back_value[104:73],
//                zero fill to 112 bits
//
// one request at a time: o_s_axis_tready is high only while the sequencer idles
// inserts, removes and clear pass S_EXEC, S_FRONT and S_BACK; read index adds S_RDIDX
// contains and remove first match scan, a removal may shift: the scan and the gap
// closing share the single read port of the entry memory, one entry a cycle
// results sit in an output register, so a new request is taken while one waits
// a stalled master holds the sequencer at its last step; reset is synchronous
module bounded_deque_with_search_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // item_value[31:0], index[35:32]
    input  logic [bdq_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // req_type[2:0]
    input  logic [bdq_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // status, found, read_value, empty_flag, entry_count, front_value, back_value
    output logic [bdq_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import bdq_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;   // slot address
    localparam int CW   = $clog2(DEPTH + 1);                 // entry count
    localparam int PW   = CW + 1;                            // position plus look-ahead
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    // slot of a position counted from the front, wrapping at DEPTH
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [AW-1:0] pos);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, pos};
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // word of DATA_WIDTH bits onto a port field, zero extended or cut
    function automatic logic [WORD_W-1:0] to_port(input logic [DATA_WIDTH-1:0] w);
        logic [63:0] t;
        t = 64'(w);
        return t[WORD_W-1:0];
    endfunction

    // entry memory
    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // control state
    t_state            r_state,  n_state;
    logic [AW-1:0]     r_front,  n_front;
    logic [CW-1:0]     r_count,  n_count;
    logic              r_out_valid, n_out_valid;

    // request and result payload
    t_req              r_req,    n_req;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [INDEX_W-1:0] r_idx,   n_idx;
    logic [AW-1:0]     r_k,      n_k;
    t_status           r_status, n_status;
    logic              r_found,  n_found;
    logic [DATA_WIDTH-1:0] r_rd, n_rd;
    logic [DATA_WIDTH-1:0] r_frontv, n_frontv;
    logic [M_TDATA_W-1:0]  r_out_data, n_out_data;

    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    logic              w_hit;
    logic [PW-1:0]     w_pos1;
    logic [PW-1:0]     w_pos2;
    logic [PW-1:0]     w_count_p;
    logic              w_range_bad;
    logic              w_out_free;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_hit       = (r_rdata == r_val);
    assign w_pos1      = PW'(r_k) + PW'(1);
    assign w_pos2      = PW'(r_k) + PW'(2);
    assign w_count_p   = PW'(r_count);
    assign w_range_bad = (CMPW'(r_idx) >= CMPW'(r_count));
    assign w_out_free  = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_req       = r_req;
        n_val       = r_val;
        n_idx       = r_idx;
        n_k         = r_k;
        n_status    = r_status;
        n_found     = r_found;
        n_rd        = r_rd;
        n_frontv    = r_frontv;
        w_we        = 1'b0;
        w_waddr     = r_front;
        w_wdata     = r_val;
        w_re        = 1'b0;
        w_raddr     = r_front;

        // result taken by the master
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req    = t_req'(i_s_axis_tuser[2:0]);
                    n_val    = DATA_WIDTH'(i_s_axis_tdata[WORD_W-1:0]);
                    n_idx    = i_s_axis_tdata[WORD_W +: INDEX_W];
                    n_status = ST_OK;
                    n_found  = 1'b0;
                    n_rd     = '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_FRONT;
                case (r_req)
                    REQ_HEAD_INSERT: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_front = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
                            w_we    = 1'b1;
                            w_waddr = n_front;
                            n_count = r_count + CW'(1);
                        end
                    end
                    REQ_TAIL_INSERT: begin
                        if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_waddr = slot(r_front, AW'(r_count));
                            n_count = r_count + CW'(1);
                        end
                    end
                    REQ_HEAD_REMOVE: begin
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_front = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
                            n_count = r_count - CW'(1);
                            n_found = 1'b1;
                        end
                    end
                    REQ_TAIL_REMOVE: begin
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_found = 1'b1;
                        end
                    end
                    REQ_CONTAINS, REQ_REMOVE_FIRST: begin
                        if (w_empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            // position 0 comes back next cycle
                            w_re    = 1'b1;
                            w_raddr = r_front;
                            n_k     = '0;
                            n_state = S_SCAN;
                        end
                    end
                    REQ_READ_INDEX: begin
                        if (w_range_bad) begin
                            n_status = ST_RANGE;
                        end else begin
                            w_re    = 1'b1;
                            w_raddr = slot(r_front, AW'(r_idx));
                            n_state = S_RDIDX;
                        end
                    end
                    REQ_CLEAR: begin
                        n_count = '0;
                        n_front = '0;
                    end
                    default: begin
                        n_state = S_FRONT;
                    end
                endcase
            end
            S_SCAN: begin
                // data of position r_k is here, fetch the next one meanwhile
                if (w_pos1 < w_count_p) begin
                    w_re    = 1'b1;
                    w_raddr = slot(r_front, AW'(w_pos1));
                end
                if (w_hit) begin
                    if (r_req == REQ_CONTAINS) begin
                        n_found = 1'b1;
                        n_state = S_FRONT;
                    end else if (w_pos1 < w_count_p) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_found = 1'b1;
                        n_state = S_FRONT;
                    end
                end else if (w_pos1 >= w_count_p) begin
                    n_status = ST_EMPTY;
                    n_state  = S_FRONT;
                end else begin
                    n_k = AW'(w_pos1);
                end
            end
            S_SHIFT: begin
                // entry r_k+1 moves into slot of r_k; writes trail the reads
                w_we    = 1'b1;
                w_waddr = slot(r_front, r_k);
                w_wdata = r_rdata;
                if (w_pos2 < w_count_p) begin
                    w_re    = 1'b1;
                    w_raddr = slot(r_front, AW'(w_pos2));
                    n_k     = AW'(w_pos1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_found = 1'b1;
                    n_state = S_FRONT;
                end
            end
            S_RDIDX: begin
                n_rd    = r_rdata;
                n_state = S_FRONT;
            end
            S_FRONT: begin
                if (!w_empty) begin
                    w_re    = 1'b1;
                    w_raddr = r_front;
                end
                n_state = S_BACK;
            end
            S_BACK: begin
                // front word arrives, fetch the back word
                n_frontv = r_rdata;
                if (!w_empty) begin
                    w_re    = 1'b1;
                    w_raddr = slot(r_front, AW'(r_count - CW'(1)));
                end
                n_state = S_IDLE;
                // stay put until the output register can take the beat
                if (!w_out_free) begin
                    n_state = S_BACK;
                    w_re    = 1'b0;
                    n_frontv = r_frontv;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // the back word lands in the cycle after S_BACK, so r_emit marks that cycle and
    // the beat is built then into a registered snapshot
    logic r_emit, n_emit;
    assign n_emit = (r_state == S_BACK) && w_out_free;

    always_comb begin
        n_out_data = r_out_data;
        if (r_emit) begin
            n_out_data = {
                7'd0,
                w_empty ? {WORD_W{1'b0}} : to_port(r_rdata),
                w_empty ? {WORD_W{1'b0}} : to_port(r_frontv),
                COUNT_W'(r_count),
                w_empty,
                to_port(r_rd),
                r_found,
                r_status
            };
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_emit      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= r_emit ? 1'b1 : n_out_valid;
            r_emit      <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_val      <= n_val;
        r_idx      <= n_idx;
        r_k        <= n_k;
        r_status   <= n_status;
        r_found    <= n_found;
        r_rd       <= n_rd;
        r_frontv   <= n_frontv;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTH
    // occupancy never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    // an accepted request always starts execution next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_EXEC))
        else $error("accepted request not executed");

    // a result beat reports emptiness that agrees with its count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[35] == (o_m_axis_tdata[40:36] == 5'd0)))
        else $error("empty flag disagrees with entry_count");

    // a snapshot is only taken into a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emit |-> !r_out_valid)
        else $error("result beat overwritten");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import bdq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_REQS = 1000;
    // cycles with no beat on either side before the run is abandoned
    localparam int IDLE_LIMIT  = 4000;
    // the receiver's long hold-off, long enough for the input to back up
    localparam int HOLD_CYCLES = 400;
    // drain time after the last expected result
    localparam int TAIL_CYCLES = 3 * DEPTH;

    typedef struct packed {
        t_status             status;
        logic                found;
        logic [WORD_W-1:0]   read_value;
        logic                empty_flag;
        logic [COUNT_W-1:0]  entry_count;
        logic [WORD_W-1:0]   front_value;
        logic [WORD_W-1:0]   back_value;
    } t_result;

    // deque contents and the results still owed by the block
    class deque_scoreboard;
        logic [WORD_W-1:0] held[$];
        t_result           awaited[$];
        int                mismatches;

        function int position_of(logic [WORD_W-1:0] value);
            for (int k = 0; k < held.size(); k++) begin
                if (held[k] == value) return k;
            end
            return -1;
        endfunction

        // applies an accepted request and queues the result it must produce
        function void note_request(t_req req, logic [WORD_W-1:0] value,
                                   logic [INDEX_W-1:0] ix);
            t_result r;
            int      hit;
            r   = '0;
            hit = position_of(value);
            case (req)
                REQ_HEAD_INSERT: begin
                    if (held.size() >= DEPTH) r.status = ST_FULL;
                    else held.push_front(value);
                end
                REQ_TAIL_INSERT: begin
                    if (held.size() >= DEPTH) r.status = ST_FULL;
                    else held.push_back(value);
                end
                REQ_HEAD_REMOVE: begin
                    if (held.size() == 0) r.status = ST_EMPTY;
                    else begin
                        void'(held.pop_front());
                        r.found = 1'b1;
                    end
                end
                REQ_TAIL_REMOVE: begin
                    if (held.size() == 0) r.status = ST_EMPTY;
                    else begin
                        void'(held.pop_back());
                        r.found = 1'b1;
                    end
                end
                REQ_CONTAINS: begin
                    if (hit < 0) r.status = ST_EMPTY;
                    else r.found = 1'b1;
                end
                REQ_REMOVE_FIRST: begin
                    if (hit < 0) r.status = ST_EMPTY;
                    else begin
                        held.delete(hit);
                        r.found = 1'b1;
                    end
                end
                REQ_READ_INDEX: begin
                    if (int'(ix) >= held.size()) r.status = ST_RANGE;
                    else r.read_value = held[ix];
                end
                REQ_CLEAR: begin
                    held.delete();
                end
            endcase
            r.entry_count = COUNT_W'(held.size());
            r.empty_flag  = (held.size() == 0);
            if (held.size() != 0) begin
                r.front_value = held[0];
                r.back_value  = held[held.size() - 1];
            end
            awaited.push_back(r);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            t_result got;
            t_result want;
            got.status      = t_status'(beat[1:0]);
            got.found       = beat[2];
            got.read_value  = beat[34:3];
            got.empty_flag  = beat[35];
            got.entry_count = beat[40:36];
            got.front_value = beat[72:41];
            got.back_value  = beat[104:73];
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected: %h", $realtime, beat);
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status || got.found !== want.found
                    || got.read_value !== want.read_value
                    || got.empty_flag !== want.empty_flag
                    || got.entry_count !== want.entry_count
                    || got.front_value !== want.front_value
                    || got.back_value !== want.back_value) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch", $realtime);
                    $display({"  expected status %0d found %0b read %h empty %0b",
                              " count %0d front %h back %h"},
                             want.status, want.found, want.read_value, want.empty_flag,
                             want.entry_count, want.front_value, want.back_value);
                    $display({"  actual   status %0d found %0b read %h empty %0b",
                              " count %0d front %h back %h"},
                             got.status, got.found, got.read_value, got.empty_flag,
                             got.entry_count, got.front_value, got.back_value);
                end
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    // item_value[31:0], index[35:32], zero fill
    logic [S_TDATA_W-1:0]   s_data = '0;
    // req_type[2:0]
    logic [S_TUSER_W-1:0]   s_user = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    // status, found, read_value, empty_flag, entry_count, front_value, back_value
    logic [M_TDATA_W-1:0]   m_data;

    deque_scoreboard sb = new();

    int burst_left = 0;     // beats left in the sender's current burst
    bit long_hold_due = 1'b0;
    int idle_cycles = 0;

    logic [WORD_W-1:0] fill_vals[16] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
        32'h5A5A_5A5A, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF,
        32'hFFFF_FFFE, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3333_CCCC,
        32'h5A5A_5A5A, 32'hCCCC_3333, 32'h0001_0000, 32'h1234_5678
    };

    bounded_deque_with_search_top #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (WORD_W)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // offers one request and returns at the edge that takes it; the sender
    // runs in bursts and may drop valid for a random gap between them
    task automatic send_req(t_req req, logic [WORD_W-1:0] value,
                            logic [INDEX_W-1:0] ix);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(0, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= {{(S_TDATA_W - WORD_W - INDEX_W){1'b0}}, ix, value};
        s_user  <= req;
        forever begin
            @(posedge clk);
            if (s_ready) break;
        end
        sb.note_request(req, value, ix);
    endtask

    // mostly values from a small set or already held so that searches hit, now and then any word
    function automatic logic [WORD_W-1:0] pick_value();
        logic [WORD_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = fill_vals[$urandom_range(0, 15)];
            4, 5, 6:    v = (sb.held.size() != 0)
                            ? sb.held[$urandom_range(0, sb.held.size() - 1)] : $urandom;
            default:    v = $urandom;
        endcase
        return v;
    endfunction

    task automatic random_reqs();
        int   phase_left;
        int   phase;        // 0 filling, 1 draining, 2 balanced
        int   ins_w;
        int   rem_w;
        int   roll;
        t_req req;
        logic [INDEX_W-1:0] ix;
        phase_left = 0;
        phase      = 2;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (phase_left == 0) begin
                phase      = $urandom_range(0, 2);
                phase_left = $urandom_range(15, 60);
            end
            phase_left--;
            ins_w = (phase == 0) ? 55 : (phase == 1) ? 10 : 25;
            rem_w = (phase == 0) ? 10 : (phase == 1) ? 45 : 22;
            roll  = $urandom_range(0, 99);
            ix    = INDEX_W'($urandom_range(0, 15));
            if (roll < ins_w)
                req = $urandom_range(0, 1) ? REQ_TAIL_INSERT : REQ_HEAD_INSERT;
            else if (roll < ins_w + rem_w)
                req = $urandom_range(0, 1) ? REQ_TAIL_REMOVE : REQ_HEAD_REMOVE;
            else if (roll < 98) begin
                case ($urandom_range(0, 2))
                    0:       req = REQ_CONTAINS;
                    1:       req = REQ_REMOVE_FIRST;
                    default: req = REQ_READ_INDEX;
                endcase
                // at least half of the reads land inside the occupied range
                if (req == REQ_READ_INDEX && sb.held.size() != 0 && $urandom_range(0, 1))
                    ix = INDEX_W'($urandom_range(0, sb.held.size() - 1));
            end else
                req = REQ_CLEAR;
            send_req(req, pick_value(), ix);
        end
    endtask

    // receiver: segments of steady, patchy or sparse ready, plus one long hold-off
    initial begin
        int mode;
        int seg_len;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                repeat (HOLD_CYCLES) begin
                    m_ready <= 1'b0;
                    @(posedge clk);
                end
            end else begin
                mode    = $urandom_range(0, 2);
                seg_len = $urandom_range(10, 80);
                repeat (seg_len) begin
                    case (mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= 1'($urandom_range(0, 1));
                        default: m_ready <= ($urandom_range(0, 4) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // result monitor, sampled at the edge that completes the beat
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) sb.check_result(m_data);
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("bounded_deque_with_search_top regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // removes and a read on an empty deque
        send_req(REQ_HEAD_REMOVE, 32'h0000_0000, 4'd0);
        send_req(REQ_TAIL_REMOVE, 32'hFFFF_FFFF, 4'd15);
        send_req(REQ_READ_INDEX, 32'h0000_0000, 4'd0);
        // fill from both ends, with a repeated word for the match removal
        for (int i = 0; i < 16; i++)
            send_req((i % 2) ? REQ_TAIL_INSERT : REQ_HEAD_INSERT, fill_vals[i],
                     INDEX_W'(i));
        // inserts into a full deque are turned away
        send_req(REQ_HEAD_INSERT, 32'hCAFE_0001, 4'd0);
        send_req(REQ_TAIL_INSERT, 32'hCAFE_0002, 4'd0);
        send_req(REQ_READ_INDEX, 32'h0000_0000, 4'd15);
        send_req(REQ_CONTAINS, 32'h1357_9BDF, 4'd0);
        send_req(REQ_CONTAINS, 32'h5A5A_5A5A, 4'd0);
        // frontmost of three equal words goes, the rest close the gap
        send_req(REQ_REMOVE_FIRST, 32'h5A5A_5A5A, 4'd0);
        send_req(REQ_READ_INDEX, 32'h0000_0000, 4'd15);
        send_req(REQ_HEAD_REMOVE, 32'h0000_0000, 4'd0);
        send_req(REQ_TAIL_REMOVE, 32'h0000_0000, 4'd0);
        send_req(REQ_CLEAR, 32'hFFFF_FFFF, 4'd15);

        // the receiver backs off while requests keep coming
        long_hold_due = 1'b1;
        random_reqs();
        s_valid <= 1'b0;

        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("bounded_deque_with_search_top regression: pass");
        else
            $display("bounded_deque_with_search_top regression: fail");
        $finish;
    end

endmodule
